// ----- design/mandel_pkg.sv -----
package mandel_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd5;

  // Register widths
  localparam int unsigned ORIGIN_W = 32;
  localparam int unsigned PITCH_W  = 31;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned DIM_W    = 13;

  // Register reset values
  localparam logic signed [ORIGIN_W-1:0] ORIGIN_REAL_RST = -32'sd536870912;
  localparam logic signed [ORIGIN_W-1:0] ORIGIN_IMAG_RST = -32'sd268435456;
  localparam logic [PITCH_W-1:0]         PITCH_RST       = 31'd268435;
  localparam logic [COUNT_W-1:0]         MAX_ITER_RST    = 16'd1000;
  localparam logic [DIM_W-1:0]           WIDTH_RST       = 13'd3000;
  localparam logic [DIM_W-1:0]           HEIGHT_RST      = 13'd2000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR,
    ST_CI,
    ST_Z0,
    ST_NEXT,
    ST_SQR,
    ST_SQI,
    ST_SUM,
    ST_DONE
  } state_e;

endpackage

// ----- design/mandel_mul.sv -----
module mandel_mul #(
  parameter int unsigned MW = 31
) (
  input  logic              clk_i,
  input  logic signed [MW:0] a_i,
  input  logic signed [MW:0] b_i,
  output logic [2*MW-1:0]   mag_o,
  output logic              neg_o
);

  logic [MW:0]     a_neg;
  logic [MW:0]     b_neg;
  logic [MW-1:0]   a_mag;
  logic [MW-1:0]   b_mag;
  logic [2*MW-1:0] mag_d;
  logic [2*MW-1:0] mag_q;
  logic            neg_d;
  logic            neg_q;

  // Sign-magnitude product: magnitudes multiply, sign applied by the user
  assign a_neg = -a_i;
  assign b_neg = -b_i;
  assign a_mag = a_i[MW] ? a_neg[MW-1:0] : a_i[MW-1:0];
  assign b_mag = b_i[MW] ? b_neg[MW-1:0] : b_i[MW-1:0];
  assign mag_d = a_mag * b_mag;
  assign neg_d = a_i[MW] ^ b_i[MW];

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ----- design/mandelbrot_escape_time.sv -----
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------------
// config    | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
// pixel in  | in        | in_valid_i / in_stall_o  | pixel_col_i, pixel_row_i
// result    | out       | out_valid_o / out_stall_i| out_col_o, out_row_o, escape_count_o,
//           |           |                        | in_range_o
//
// Sequence: an in-range pixel passes the setup states CR, CI and Z0, then runs the states
// NEXT, SQR, SQI and SUM for each iteration, then DONE hands over the result. The loop
// has these states because the one registered multiplier forms zr*zi,
// zr*zr and zi*zi in turn. A pixel outside the image, or a zero limit, skips to DONE.
// Reset clears the sequencer and output valid and loads the register defaults.
// A stalled result sits in the output register while the next pixel is accepted.
module mandelbrot_escape_time #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mandel_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mandel_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [COORD_BITS-1:0]               pixel_col_i,
  input  logic [COORD_BITS-1:0]               pixel_row_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [COORD_BITS-1:0]               out_col_o,
  output logic [COORD_BITS-1:0]               out_row_o,
  output logic [mandel_pkg::COUNT_W-1:0]      escape_count_o,
  output logic                                in_range_o
);

  import mandel_pkg::*;

  // Multiplier magnitude width: covers |z| < 2^(F+1) and the 31-bit pitch
  localparam int unsigned MW   = (FRAC_BITS + 1 > PITCH_W) ? FRAC_BITS + 1 : PITCH_W;
  // c coordinate: coord*pitch plus signed origin
  localparam int unsigned CW   = COORD_BITS + PITCH_W + 2;
  // z components: |z| < 2^(F+1)
  localparam int unsigned ZW   = FRAC_BITS + 2;
  // truncated products and squares: below 2^(F+2)
  localparam int unsigned SQW  = FRAC_BITS + 2;
  // candidate z before the escape test
  localparam int unsigned NW   = ((CW > FRAC_BITS + 4) ? CW : FRAC_BITS + 4) + 2;
  // pixel compare width
  localparam int unsigned CMPW = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

  localparam logic signed [NW-1:0] LIM     = {{(NW-FRAC_BITS-2){1'b0}}, 1'b1,
                                              {(FRAC_BITS+1){1'b0}}};
  localparam logic signed [NW-1:0] NEG_LIM = -LIM;
  localparam logic [SQW:0]         FOUR    = {1'b1, {(SQW){1'b0}}};

  // Configuration registers
  logic signed [ORIGIN_W-1:0] ore_q;
  logic signed [ORIGIN_W-1:0] oim_q;
  logic [PITCH_W-1:0]         pitch_q;
  logic [COUNT_W-1:0]         max_iter_q;
  logic [DIM_W-1:0]           width_q;
  logic [DIM_W-1:0]           height_q;

  // Sequencer and working registers
  state_e                     state_q, state_d;
  logic [COORD_BITS-1:0]      col_q, col_d;
  logic [COORD_BITS-1:0]      row_q, row_d;
  logic                       inr_q, inr_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic [COUNT_W-1:0]         iter_q, iter_d;
  logic signed [CW-1:0]       cr_q, cr_d;
  logic signed [CW-1:0]       ci_q, ci_d;
  logic signed [ZW-1:0]       zr_q, zr_d;
  logic signed [ZW-1:0]       zi_q, zi_d;
  logic [SQW-1:0]             sr_q, sr_d;
  logic [SQW-1:0]             si_q, si_d;

  // Output register
  logic                       oval_q, oval_d;
  logic [COORD_BITS-1:0]      ocol_q, ocol_d;
  logic [COORD_BITS-1:0]      orow_q, orow_d;
  logic [COUNT_W-1:0]         ocnt_q, ocnt_d;
  logic                       oinr_q, oinr_d;

  // Shared multiplier
  logic signed [MW:0]         mul_a;
  logic signed [MW:0]         mul_b;
  logic [2*MW-1:0]            prod_mag;
  logic                       prod_neg;

  // Datapath nets
  logic                       inside_w;
  logic                       accept_w;
  logic                       out_free_w;
  logic [SQW-1:0]             shr_w;
  logic signed [SQW:0]        cross_w;
  logic signed [CW-1:0]       coord_prod_w;
  logic signed [NW-1:0]       nr_w;
  logic signed [NW-1:0]       ni_w;
  logic                       escape_w;
  logic [SQW:0]               sum_w;
  logic                       sum_hit_w;
  logic                       last_iter_w;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ore_q      <= ORIGIN_REAL_RST;
      oim_q      <= ORIGIN_IMAG_RST;
      pitch_q    <= PITCH_RST;
      max_iter_q <= MAX_ITER_RST;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_REAL:    ore_q      <= cfg_wdata_i[ORIGIN_W-1:0];
        CFG_ORIGIN_IMAG:    oim_q      <= cfg_wdata_i[ORIGIN_W-1:0];
        CFG_PIXEL_PITCH:    pitch_q    <= cfg_wdata_i[PITCH_W-1:0];
        CFG_MAX_ITERATIONS: max_iter_q <= cfg_wdata_i[COUNT_W-1:0];
        CFG_IMAGE_WIDTH:    width_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   height_q   <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept_w   = in_valid_i && !in_stall_o;
  assign out_free_w = !oval_q || !out_stall_i;
  assign inside_w   = (CMPW'(pixel_col_i) < CMPW'(width_q)) &&
                      (CMPW'(pixel_row_i) < CMPW'(height_q));

  // ---------------------------------------------------------------------------
  // Shared multiplier: operand select by step
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = (MW+1)'(zr_q);
    mul_b = (MW+1)'(zi_q);
    unique case (state_q)
      ST_CR: begin
        mul_a = (MW+1)'(col_q);
        mul_b = (MW+1)'(pitch_q);
      end
      ST_CI: begin
        mul_a = (MW+1)'(row_q);
        mul_b = (MW+1)'(pitch_q);
      end
      ST_SQR: begin
        mul_a = (MW+1)'(zr_q);
        mul_b = (MW+1)'(zr_q);
      end
      ST_SQI: begin
        mul_a = (MW+1)'(zi_q);
        mul_b = (MW+1)'(zi_q);
      end
      default: ;
    endcase
  end

  mandel_mul #(
    .MW (MW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .mag_o (prod_mag),
    .neg_o (prod_neg)
  );

  // Truncate the magnitude by FRAC_BITS, then apply the sign
  assign shr_w        = prod_mag[2*FRAC_BITS+1:FRAC_BITS];
  assign cross_w      = prod_neg ? -$signed({1'b0, shr_w}) : $signed({1'b0, shr_w});
  assign coord_prod_w = $signed(CW'(prod_mag[COORD_BITS+PITCH_W-1:0]));

  // New z and the coarse bound test
  assign nr_w     = $signed(NW'(sr_q)) - $signed(NW'(si_q)) + NW'(cr_q);
  assign ni_w     = NW'(cross_w) + NW'(cross_w) + NW'(ci_q);
  assign escape_w = (nr_w >= LIM) || (nr_w <= NEG_LIM) ||
                    (ni_w >= LIM) || (ni_w <= NEG_LIM);

  // Magnitude test on the squares
  assign sum_w       = {1'b0, sr_q} + {1'b0, shr_w};
  assign sum_hit_w   = (sum_w >= FOUR);
  assign last_iter_w = (iter_q == max_iter_q);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          state_d = (inside_w && (max_iter_q != '0)) ? ST_CR : ST_DONE;
        end
      end
      ST_CR:   state_d = ST_CI;
      ST_CI:   state_d = ST_Z0;
      ST_Z0:   state_d = ST_NEXT;
      ST_NEXT: state_d = escape_w ? ST_DONE : ST_SQR;
      ST_SQR:  state_d = ST_SQI;
      ST_SQI:  state_d = ST_SUM;
      ST_SUM:  state_d = (sum_hit_w || last_iter_w) ? ST_DONE : ST_NEXT;
      ST_DONE: begin
        if (out_free_w) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and output register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    inr_d   = inr_q;
    count_d = count_q;
    iter_d  = iter_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    sr_d    = sr_q;
    si_d    = si_q;
    oval_d  = oval_q && out_stall_i;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    ocnt_d  = ocnt_q;
    oinr_d  = oinr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          // latch the pixel, start from z = 0
          col_d   = pixel_col_i;
          row_d   = pixel_row_i;
          inr_d   = inside_w;
          count_d = '0;
          iter_d  = COUNT_W'(1);
          zr_d    = '0;
          zi_d    = '0;
          sr_d    = '0;
          si_d    = '0;
        end
      end
      ST_CI: cr_d = coord_prod_w + CW'(ore_q);
      ST_Z0: ci_d = coord_prod_w + CW'(oim_q);
      ST_NEXT: begin
        zr_d = nr_w[ZW-1:0];
        zi_d = ni_w[ZW-1:0];
        if (escape_w) begin
          count_d = iter_q;
        end
      end
      ST_SQI: sr_d = shr_w;
      ST_SUM: begin
        si_d = shr_w;
        if (sum_hit_w) begin
          count_d = iter_q;
        end else if (!last_iter_w) begin
          iter_d = iter_q + COUNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free_w) begin
          // hand over the result
          oval_d = 1'b1;
          ocol_d = col_q;
          orow_d = row_q;
          ocnt_d = count_q;
          oinr_d = inr_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    inr_q   <= inr_d;
    count_q <= count_d;
    iter_q  <= iter_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    sr_q    <= sr_d;
    si_q    <= si_d;
    ocol_q  <= ocol_d;
    orow_q  <= orow_d;
    ocnt_q  <= ocnt_d;
    oinr_q  <= oinr_d;
  end

  assign out_valid_o    = oval_q;
  assign out_col_o      = ocol_q;
  assign out_row_o      = orow_q;
  assign escape_count_o = ocnt_q;
  assign in_range_o     = oinr_q;

endmodule

// ----- sim/tb.sv -----
module tb;
  import mandel_pkg::*;

  localparam int COORD_W = 12;
  localparam int FRAC_W  = 28;
  // Escape by component once |z| reaches 2, by magnitude once zr^2 + zi^2 reaches 4.
  localparam longint ESC_LIM = longint'(1) << (FRAC_W + 1);
  localparam longint ESC_SUM = longint'(4) << FRAC_W;
  // Multiplier operands keep 42 magnitude bits; a scaled product keeps 62.
  localparam int MAG_W  = 42;
  localparam int KEEP_W = 62;

  localparam int MAX_GAP         = 18;
  localparam int TOTAL_PIXELS    = 576;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_CYCLES = 1000000;
  localparam int REPORT_LIMIT    = 40;

  // Indexes that decode to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

  // Handy points of the complex plane, Q4.28.
  localparam int FX_ONE      = 268435456;
  localparam int FX_MINUS_2  = -536870912;
  localparam int FX_CUSP     = 67108864 + 4096;  // just right of 0.25, escapes slowly

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COUNT_W-1:0] count;
    logic               in_range;
  } pixel_result_t;

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [COORD_W-1:0]    pixel_col_i    = '0;
  logic [COORD_W-1:0]    pixel_row_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [COORD_W-1:0]    out_col_o;
  logic [COORD_W-1:0]    out_row_o;
  logic [COUNT_W-1:0]    escape_count_o;
  logic                  in_range_o;

  mandelbrot_escape_time #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .escape_count_o(escape_count_o),
    .in_range_o    (in_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Shadow of the register file, starting from the reset values.
  logic signed [ORIGIN_W-1:0] view_re         = ORIGIN_REAL_RST;
  logic signed [ORIGIN_W-1:0] view_im         = ORIGIN_IMAG_RST;
  logic [PITCH_W-1:0]         view_pitch      = PITCH_RST;
  logic [COUNT_W-1:0]         view_iter_limit = MAX_ITER_RST;
  logic [DIM_W-1:0]           view_width      = WIDTH_RST;
  logic [DIM_W-1:0]           view_height     = HEIGHT_RST;

  pixel_result_t expected_px[$];

  bit idle_on      = 1'b0;  // both sides draw random waits while set
  int hold_request = 0;     // long output hold, picked up by the result sink
  int pixels_sent  = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int views        = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  // Scaled product: multiply the magnitudes exactly, drop the fraction bits
  // (truncation toward zero), then restore the sign.
  function automatic longint fixed_mul(longint a, longint b);
    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [127:0] prod;
    longint       mag;
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    mag_a[63:MAG_W] = '0;
    mag_b[63:MAG_W] = '0;
    prod = {64'b0, mag_a} * {64'b0, mag_b};
    mag = longint'({2'b00, prod[FRAC_W +: KEEP_W]});
    return ((a < 0) != (b < 0)) ? -mag : mag;
  endfunction

  // Escape-time count of one pixel under the current register settings.
  function automatic pixel_result_t escape_time_of(logic [COORD_W-1:0] col,
                                                   logic [COORD_W-1:0] row);
    pixel_result_t res;
    longint        c_re, c_im, z_re, z_im, sq_re, sq_im, n_re, n_im, cross_term;
    int unsigned   iter;
    res.col      = col;
    res.row      = row;
    res.count    = '0;
    res.in_range = (col < view_width) && (row < view_height);
    if (res.in_range) begin
      c_re  = longint'(col) * longint'(view_pitch) + longint'(view_re);
      c_im  = longint'(row) * longint'(view_pitch) + longint'(view_im);
      z_re  = 0;
      z_im  = 0;
      sq_re = 0;
      sq_im = 0;
      for (iter = 1; iter <= view_iter_limit; iter++) begin
        cross_term = fixed_mul(z_re, z_im);
        n_re  = sq_re - sq_im + c_re;
        n_im  = 2 * cross_term + c_im;
        if (n_re >= ESC_LIM || n_re <= -ESC_LIM || n_im >= ESC_LIM || n_im <= -ESC_LIM) begin
          res.count = COUNT_W'(iter);
          break;
        end
        sq_re = fixed_mul(n_re, n_re);
        sq_im = fixed_mul(n_im, n_im);
        z_re  = n_re;
        z_im  = n_im;
        if (sq_re + sq_im >= ESC_SUM) begin
          res.count = COUNT_W'(iter);
          break;
        end
      end
    end
    return res;
  endfunction

  // Offer one pixel after a random gap and hold it until the block takes it.
  // Valid stays high afterwards so a zero gap gives back-to-back transactions.
  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_px.push_back(escape_time_of(col, row));
    pixels_sent++;
  endtask

  // Drop valid, drain every outstanding result and let the sequencer settle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ORIGIN_REAL:    view_re         = data[ORIGIN_W-1:0];
      CFG_ORIGIN_IMAG:    view_im         = data[ORIGIN_W-1:0];
      CFG_PIXEL_PITCH:    view_pitch      = data[PITCH_W-1:0];
      CFG_MAX_ITERATIONS: view_iter_limit = data[COUNT_W-1:0];
      CFG_IMAGE_WIDTH:    view_width      = data[DIM_W-1:0];
      CFG_IMAGE_HEIGHT:   view_height     = data[DIM_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Load a complete view once the block has gone idle.
  task automatic set_view(input logic [CFG_DATA_W-1:0] re, input logic [CFG_DATA_W-1:0] im,
                          input logic [CFG_DATA_W-1:0] pitch, input logic [CFG_DATA_W-1:0] iters,
                          input logic [CFG_DATA_W-1:0] width,
                          input logic [CFG_DATA_W-1:0] height);
    settle();
    write_reg(CFG_ORIGIN_REAL, re);
    write_reg(CFG_ORIGIN_IMAG, im);
    write_reg(CFG_PIXEL_PITCH, pitch);
    write_reg(CFG_MAX_ITERATIONS, iters);
    write_reg(CFG_IMAGE_WIDTH, width);
    write_reg(CFG_IMAGE_HEIGHT, height);
    views++;
  endtask

  // Draw a view: mostly the classic full set, some deep zooms on the boundary,
  // a few with random register values. Returns the useful coordinate span.
  task automatic random_view(output int span);
    int kind, n, pitch, re, im, iters, width, height;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(8, 96);
    if (kind < 6) begin
      pitch  = (3 * FX_ONE) / n + $urandom_range(0, 1023);
      re     = FX_MINUS_2 + int'($urandom_range(0, 67108864)) - 33554432;
      im     = -402653184 + int'($urandom_range(0, 67108864)) - 33554432;
      iters  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 64);
      width  = n + $urandom_range(0, 8) - 4;
      height = n + $urandom_range(0, 8) - 4;
      span   = n + 8;
    end else if (kind < 8) begin
      pitch  = FX_ONE >> $urandom_range(8, 20);
      re     = -201326592 - (n / 2) * pitch;
      im     = 26843545 - (n / 2) * pitch;
      iters  = $urandom_range(20, 200);
      width  = n;
      height = n;
      span   = n + 4;
    end else begin
      pitch  = $urandom;
      re     = $urandom;
      im     = $urandom;
      // random upper bits are dropped by the 16-bit register
      iters  = int'(($urandom_range(0, 65535) << 16) | $urandom_range(1, 64));
      width  = $urandom;
      height = $urandom;
      span   = (1 << COORD_W) - 1;
    end
    set_view(re, im, pitch, iters, width, height);
  endtask

  // Check each result against the oldest prediction.
  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    pixel_result_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, expected none, actual col %0d row %0d",
                 $time, out_col_o, out_row_o);
      end else begin
        want = expected_px.pop_front();
        check_field("out_col", want.col, out_col_o);
        check_field("out_row", want.row, out_row_o);
        check_field("escape_count", want.count, escape_count_o);
        check_field("in_range", want.in_range, in_range_o);
      end
    end
  end

  // Result sink: after each transaction wait a random number of offered
  // cycles; a long hold requested by a test is counted down here.
  initial begin : result_sink
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      if (out_valid_o && !out_stall_i)
        gap_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      else if (out_valid_o && gap_left > 0)
        gap_left--;
      out_stall_i <= (hold_left > 0) || (gap_left > 0);
    end
  end

  // Abort if neither channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transaction for %0d cycles, %0d results pending",
               $time, quiet_cycles, expected_px.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Reset values: corners of the default 3000 x 2000 image, a point near the
  // origin that never escapes, and pixels just past each edge.
  task automatic test_reset_defaults();
    send_pixel(0, 0);
    send_pixel(2000, 1000);
    send_pixel(2999, 1999);
    send_pixel(3000, 0);
    send_pixel(5, 2000);
    send_pixel(4095, 4095);
  endtask

  task automatic test_register_extremes();
    // smallest image and a single iteration
    set_view(0, 0, 0, 1, 1, 1);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    // most negative origin, widest pitch, full 4096 x 4096 image
    set_view(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8, 4096, 4096);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    // most positive origin, zero pitch
    set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 8, 4096, 4096);
    send_pixel(7, 9);
    // zero width, then zero height, then both at their field maximum
    set_view(0, 0, 1000, 8, 0, 8191);
    send_pixel(0, 0);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 8191);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    send_pixel(0, 0);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 8191);
    send_pixel(4095, 4095);
    // zero iteration limit: in range but never counted
    settle();
    write_reg(CFG_MAX_ITERATIONS, 0);
    send_pixel(1, 1);
    // full iteration limit: the origin never escapes, the cusp escapes late
    set_view(0, 0, 0, 65535, 16, 16);
    send_pixel(3, 3);
    set_view(FX_CUSP, 0, 0, 65535, 16, 16);
    send_pixel(0, 0);
  endtask

  task automatic test_special_cases();
    // real part exactly -2 escapes on the first step; one step inside does not
    set_view(FX_MINUS_2, 0, 0, 40, 1, 1);
    send_pixel(0, 0);
    set_view(FX_MINUS_2 + 1, 0, 0, 40, 1, 1);
    send_pixel(0, 0);
    // imaginary part exactly 2
    set_view(0, -FX_MINUS_2, 0, 40, 1, 1);
    send_pixel(0, 0);
    // negative odd operands exercise truncation toward zero
    set_view(-80530637, -147639501, 1, 200, 4096, 4096);
    send_pixel(4095, 1234);
    // unmapped indexes leave the view alone
    settle();
    write_reg(REG_UNMAPPED_A, '1);
    write_reg(REG_UNMAPPED_B, '1);
    send_pixel(2, 3);
    // bits above each register's width are dropped
    settle();
    write_reg(CFG_PIXEL_PITCH, 32'h8000_0003);
    write_reg(CFG_MAX_ITERATIONS, 32'hFFFF_0007);
    write_reg(CFG_IMAGE_WIDTH, 32'hFFFF_E005);
    write_reg(CFG_IMAGE_HEIGHT, 32'h0000_2006);
    send_pixel(4, 5);
    send_pixel(5, 5);
    send_pixel(4, 6);
  endtask

  task automatic test_random_views();
    int span;
    int count;
    while (pixels_sent < TOTAL_PIXELS) begin
      random_view(span);
      idle_on = ($urandom_range(0, 3) != 0);
      count   = $urandom_range(10, 40);
      repeat (count) begin
        if ($urandom_range(0, 7) == 0)
          send_pixel(COORD_W'($urandom_range(0, (1 << COORD_W) - 1)),
                     COORD_W'($urandom_range(0, (1 << COORD_W) - 1)));
        else
          send_pixel(COORD_W'($urandom_range(0, span)), COORD_W'($urandom_range(0, span)));
      end
    end
  endtask

  // Hold the output for a long stretch while pixels keep coming, so the
  // output register fills and the block stalls its input.
  task automatic test_output_hold();
    set_view(FX_MINUS_2, -402653184, (3 * FX_ONE) / 32, 8, 40, 40);
    idle_on      = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (24) send_pixel(COORD_W'($urandom_range(0, 47)), COORD_W'($urandom_range(0, 47)));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_special_cases();
    test_random_views();
    test_output_hold();

    settle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d pixels over %0d views with %0d register writes;",
             pixels_sent, views, reg_writes);
    $display("checked %0d results, %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mandel_pkg.sv
design/mandel_mul.sv
design/mandelbrot_escape_time.sv
sim/tb.sv
